// File: src/psc_pkg.sv
// Shared types and codes for the pressure sensor compensation block.
// Holds the item structs and the configuration register indexes; no dependencies.
`default_nettype none

package psc_pkg;

  // Register index on the configuration port
  typedef enum logic [1:0] {
    REG_TEMP_CALIB    = 2'd0,
    REG_PRESS_CALIB_A = 2'd1,
    REG_PRESS_CALIB_B = 2'd2,
    REG_PRESS_CALIB_C = 2'd3
  } cfg_reg_t;

  localparam int CFG_DATA_W = 48;

  typedef struct packed {
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pressure_out;
    logic signed [23:0] temperature_lin;
  } out_item_t;

endpackage

`default_nettype wire

// File: src/psc_temp.sv
// Four-stage temperature linearization datapath.
// Needs only the raw temperature and the temperature calibration word.
`default_nettype none

module psc_temp #(
  parameter int TEMP_FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               adv,
  input  wire logic [23:0]        raw_temperature,
  input  wire logic [39:0]        temp_calib,
  output logic signed [23:0]      temp_lin
);

  localparam int TSH = 48 - TEMP_FRAC_BITS;
  localparam logic signed [60:0] TLIN_MAX = 61'sd8388607;
  localparam logic signed [60:0] TLIN_MIN = -61'sd8388608;

  logic signed [16:0] t2s;
  logic signed [7:0]  t3s;
  logic signed [24:0] d;
  logic signed [41:0] dt2;
  logic signed [49:0] dd;
  logic signed [41:0] dt2_q;
  logic signed [57:0] ddt3;
  logic signed [60:0] num;
  logic signed [60:0] tsh;

  assign t2s = $signed({1'b0, temp_calib[31:16]});
  assign t3s = $signed(temp_calib[39:32]);

  // Sum the two terms in units of 2^-48 and floor to the output scale
  assign num = (61'(dt2_q) <<< 18) + 61'(ddt3);
  assign tsh = num >>> TSH;

  // Advance all stages together
  always_ff @(posedge clk) begin
    if (adv) begin
      d     <= $signed({1'b0, raw_temperature}) - $signed({1'b0, temp_calib[15:0], 8'h00});
      dt2   <= d * t2s;
      dd    <= d * d;
      dt2_q <= dt2;
      ddt3  <= dd * t3s;
      if (tsh > TLIN_MAX) begin
        temp_lin <= 24'(TLIN_MAX);
      end else if (tsh < TLIN_MIN) begin
        temp_lin <= 24'(TLIN_MIN);
      end else begin
        temp_lin <= 24'(tsh);
      end
    end
  end

endmodule

`default_nettype wire

// File: src/pressure_sensor_compensation.sv
// Pressure sensor compensation, 11-stage pipeline, one item per cycle while the output is not stalled.
// Throughput is set by the pipeline advancing as a whole; a stalled output holds every stage.
// Synchronous active-high reset clears the valid bits and the four calibration registers.
// Depends on psc_pkg and psc_temp.
`default_nettype none

module pressure_sensor_compensation #(
  parameter int PRESS_FRAC_BITS = 6,
  parameter int TEMP_FRAC_BITS  = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire psc_pkg::in_item_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output psc_pkg::out_item_t                 out_data,
  input  wire logic                          cfg_write,
  input  wire psc_pkg::cfg_reg_t             cfg_index,
  input  wire logic [psc_pkg::CFG_DATA_W-1:0] cfg_data
);

  import psc_pkg::*;

  localparam int NSTG = 11;
  localparam int DS   = (3 * TEMP_FRAC_BITS + 37 > 65) ? 3 * TEMP_FRAC_BITS + 37 : 65;
  localparam int SH_A = DS + 3;
  localparam int SH_B = DS - 6 - TEMP_FRAC_BITS;
  localparam int SH_C = DS - 8 - 2 * TEMP_FRAC_BITS;
  localparam int SH_E = DS - 15 - 3 * TEMP_FRAC_BITS;
  localparam int SH_G = DS - 20;
  localparam int SH_H = DS - 29 - TEMP_FRAC_BITS;
  localparam int SH_I = DS - 32 - 2 * TEMP_FRAC_BITS;
  localparam int SH_J = DS - 37 - 3 * TEMP_FRAC_BITS;
  localparam int SH_K = DS - 48;
  localparam int SH_L = DS - 48 - TEMP_FRAC_BITS;
  localparam int SH_M = DS - 65;
  localparam int SH_OUT = DS - PRESS_FRAC_BITS;
  localparam logic signed [127:0] P_MAX = 128'sd2147483647;
  localparam logic signed [127:0] P_MIN = -128'sd2147483648;

  // Calibration registers
  logic [39:0] temp_calib;
  logic [47:0] press_a;
  logic [47:0] press_b;
  logic [31:0] press_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calib <= '0;
      press_a    <= '0;
      press_b    <= '0;
      press_c    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TEMP_CALIB:    temp_calib <= cfg_data[39:0];
        REG_PRESS_CALIB_A: press_a    <= cfg_data[47:0];
        REG_PRESS_CALIB_B: press_b    <= cfg_data[47:0];
        REG_PRESS_CALIB_C: press_c    <= cfg_data[31:0];
        default:           temp_calib <= temp_calib;
      endcase
    end
  end

  // Coefficients
  logic signed [16:0] p1m, p2m, p6s;
  logic signed [7:0]  p3, p4, p7, p8, p10, p11;
  logic signed [15:0] p9;
  logic [15:0]        p5;

  assign p1m = 17'($signed(press_a[15:0])) - 17'sd16384;
  assign p2m = 17'($signed(press_a[31:16])) - 17'sd16384;
  assign p3  = $signed(press_a[39:32]);
  assign p4  = $signed(press_a[47:40]);
  assign p5  = press_b[15:0];
  assign p6s = $signed({1'b0, press_b[31:16]});
  assign p7  = $signed(press_b[39:32]);
  assign p8  = $signed(press_b[47:40]);
  assign p9  = $signed(press_c[15:0]);
  assign p10 = $signed(press_c[23:16]);
  assign p11 = $signed(press_c[31:24]);

  // Pipeline control: hold every stage while the output item waits
  logic            adv;
  logic [NSTG-1:0] vld;

  assign adv       = !(vld[NSTG-1] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], in_valid};
    end
  end

  // Stages 1 to 4: temperature
  logic signed [23:0] tl4;
  logic [23:0]        u_d [4];

  psc_temp #(
    .TEMP_FRAC_BITS(TEMP_FRAC_BITS)
  ) u_temp (
    .clk             (clk),
    .adv             (adv),
    .raw_temperature (in_data.raw_temperature),
    .temp_calib      (temp_calib),
    .temp_lin        (tl4)
  );

  // Stage 5 to 11 registers
  logic signed [24:0]  us4;
  logic signed [23:0]  tl5, tl6, tl7, tl8, tl9, tl10;
  logic signed [24:0]  u5;
  logic signed [47:0]  t2_5;
  logic signed [48:0]  ut5, u2_5;
  logic signed [40:0]  b5, b6, b7;
  logic signed [41:0]  g5, g6, g7;
  logic signed [71:0]  t3_6;
  logic signed [72:0]  ut2_6, u2t_6;
  logic signed [73:0]  u3_6;
  logic signed [55:0]  c6, c7;
  logic signed [64:0]  k6, k7;
  logic signed [65:0]  h6, h7;
  logic signed [60:0]  pl7, ph7;
  logic signed [79:0]  e7;
  logic signed [80:0]  i7, l7;
  logic signed [81:0]  m7;
  logic signed [96:0]  ut3_8;
  logic signed [127:0] s1_8, s2_8, s3_8, s12_9, s3_9, acc10;
  logic signed [104:0] j9;

  assign us4 = $signed({1'b0, u_d[3]});

  // Align terms to the common scale
  logic signed [127:0] a_w, b_w, c_w, e_w, g_w, h_w, i_w, j_w, k_w, l_w, m_w, r_w;

  assign a_w = 128'({1'b0, p5}) <<< SH_A;
  assign b_w = 128'(b7) <<< SH_B;
  assign c_w = 128'(c7) <<< SH_C;
  assign e_w = 128'(e7) <<< SH_E;
  assign g_w = 128'(g7) <<< SH_G;
  assign h_w = 128'(h7) <<< SH_H;
  assign i_w = 128'(i7) <<< SH_I;
  assign k_w = 128'(k7) <<< SH_K;
  assign l_w = 128'(l7) <<< SH_L;
  assign m_w = 128'(m7) <<< SH_M;
  assign j_w = 128'(j9) <<< SH_J;
  assign r_w = acc10 >>> SH_OUT;

  always_ff @(posedge clk) begin
    if (adv) begin
      // Carry the raw pressure alongside the temperature stages
      u_d[0] <= in_data.raw_pressure;
      u_d[1] <= u_d[0];
      u_d[2] <= u_d[1];
      u_d[3] <= u_d[2];
      // Stage 5: squares and first products
      tl5  <= tl4;
      u5   <= us4;
      t2_5 <= tl4 * tl4;
      ut5  <= us4 * tl4;
      u2_5 <= us4 * us4;
      b5   <= p6s * tl4;
      g5   <= p1m * us4;
      // Stage 6: cubes and second-order terms
      tl6   <= tl5;
      b6    <= b5;
      g6    <= g5;
      t3_6  <= t2_5 * tl5;
      ut2_6 <= ut5 * tl5;
      u2t_6 <= u2_5 * tl5;
      u3_6  <= u2_5 * u5;
      c6    <= p7 * t2_5;
      k6    <= p9 * u2_5;
      h6    <= p2m * ut5;
      // Stage 7: split product for u*t^3, remaining coefficient terms
      tl7 <= tl6;
      b7  <= b6;
      g7  <= g6;
      c7  <= c6;
      k7  <= k6;
      h7  <= h6;
      pl7 <= $signed({1'b0, ut2_6[35:0]}) * tl6;
      ph7 <= $signed(ut2_6[72:36]) * tl6;
      e7  <= p8 * t3_6;
      i7  <= p3 * ut2_6;
      l7  <= p10 * u2t_6;
      m7  <= p11 * u3_6;
      // Stage 8: join the split product, first partial sums
      tl8   <= tl7;
      ut3_8 <= (97'(ph7) <<< 36) + 97'(pl7);
      s1_8  <= a_w + b_w + c_w + g_w;
      s2_8  <= h_w + k_w;
      s3_8  <= e_w + i_w + l_w + m_w;
      // Stage 9: last coefficient term
      tl9   <= tl8;
      j9    <= p4 * ut3_8;
      s12_9 <= s1_8 + s2_8;
      s3_9  <= s3_8;
      // Stage 10: total
      tl10  <= tl9;
      acc10 <= s12_9 + s3_9 + j_w;
      // Stage 11: floor to output scale and saturate
      out_data.temperature_lin <= tl10;
      if (r_w > P_MAX) begin
        out_data.pressure_out <= 32'(P_MAX);
      end else if (r_w < P_MIN) begin
        out_data.pressure_out <= 32'(P_MIN);
      end else begin
        out_data.pressure_out <= 32'(r_w);
      end
    end
  end

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for pressure_sensor_compensation: random valid/stall traffic,
// a bit-exact wide-integer predictor and an in-order scoreboard. Depends on psc_pkg and pressure_sensor_compensation.
`default_nettype none

module tb_top;
  import psc_pkg::*;

  typedef logic signed [255:0] wide_t;

  localparam int   PIPE_CYCLES = 11;
  localparam int   CYCLE_LIMIT = 200000;
  localparam int   N_RANDOM    = 600;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_write = 1'b0;
  cfg_reg_t  cfg_index = REG_TEMP_CALIB;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pressure_sensor_compensation u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Calibration words as the block should hold them
  logic [39:0] temp_cal;
  logic [47:0] press_cal_a, press_cal_b;
  logic [31:0] press_cal_c;

  out_item_t expected_q[$];
  int        accepted_items = 0;
  int        checked_items = 0;
  int        error_count = 0;
  int        cycle_count = 0;
  int        sat_items = 0;
  bit        hold_off_req = 1'b0;

  // Expectation typed in for the current item, when known at a glance
  bit        pend_known = 1'b0;
  out_item_t pend_result;

  // Linearized temperature and compensated pressure, exact integer arithmetic
  function automatic out_item_t compensate(in_item_t x);
    const wide_t PMAX = 2147483647;
    const wide_t PMIN = -PMAX - 1;
    longint d, k2, k3, num, tl;
    wide_t  u, u2, u3, t, t2, t3, acc, r;
    out_item_t res;
    d   = longint'(x.raw_temperature) - 256 * longint'(temp_cal[15:0]);
    k2  = longint'(temp_cal[31:16]);
    k3  = longint'($signed(temp_cal[39:32]));
    num = d * k2 * 262144 + d * d * k3;
    tl  = num >>> 32;
    if (tl > 8388607) tl = 8388607;
    if (tl < -8388608) tl = -8388608;
    res.temperature_lin = tl[23:0];

    u  = wide_t'({1'b0, x.raw_pressure});
    u2 = u * u;
    u3 = u2 * u;
    t  = wide_t'(tl);
    t2 = t * t;
    t3 = t2 * t;
    acc = wide_t'({1'b0, press_cal_b[15:0]}) <<< 88;
    acc += (wide_t'({1'b0, press_cal_b[31:16]}) * t) <<< 63;
    acc += (wide_t'($signed(press_cal_b[39:32])) * t2) <<< 45;
    acc += (wide_t'($signed(press_cal_b[47:40])) * t3) <<< 22;
    acc += ((wide_t'($signed(press_cal_a[15:0])) - 16384) * u) <<< 65;
    acc += ((wide_t'($signed(press_cal_a[31:16])) - 16384) * u * t) <<< 40;
    acc += (wide_t'($signed(press_cal_a[39:32])) * u * t2) <<< 21;
    acc += wide_t'($signed(press_cal_a[47:40])) * u * t3;
    acc += (wide_t'($signed(press_cal_c[15:0])) * u2) <<< 37;
    acc += (wide_t'($signed(press_cal_c[23:16])) * u2 * t) <<< 21;
    acc += (wide_t'($signed(press_cal_c[31:24])) * u3) <<< 20;
    r = acc >>> 79;
    if (r > PMAX) r = PMAX;
    if (r < PMIN) r = PMIN;
    res.pressure_out = r[31:0];
    return res;
  endfunction

  // Record each accepted item with its expected result
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && in_valid && !in_stall) begin
      if (pend_known) expected_q.push_back(pend_result);
      else expected_q.push_back(compensate(in_data));
      accepted_items <= accepted_items + 1;
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    out_item_t exp_item;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("result with no item outstanding: %0d %0d",
               out_data.pressure_out, out_data.temperature_lin);
        error_count++;
      end else begin
        exp_item = expected_q.pop_front();
        checked_items++;
        if (exp_item.temperature_lin == 24'sh7FFFFF || exp_item.temperature_lin == 24'sh800000)
          sat_items++;
        if (out_data.pressure_out !== exp_item.pressure_out) begin
          $error("pressure_out expected %0d actual %0d",
                 exp_item.pressure_out, out_data.pressure_out);
          error_count++;
        end
        if (out_data.temperature_lin !== exp_item.temperature_lin) begin
          $error("temperature_lin expected %0d actual %0d",
                 exp_item.temperature_lin, out_data.temperature_lin);
          error_count++;
        end
      end
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Stall the output: free-running, random, or alternating, plus one long hold
  initial begin
    int mode, len;
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (80) @(negedge clk);
        hold_off_req = 1'b0;
      end
      mode = $urandom_range(2);
      len  = $urandom_range(60, 5);
      repeat (len) begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(99) < 35);
          default: out_stall <= ~out_stall;
        endcase
        @(negedge clk);
      end
    end
  end

  // Write one register and track it; called only while idle, enable dropped by the caller
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_TEMP_CALIB:    temp_cal    = value[39:0];
      REG_PRESS_CALIB_A: press_cal_a = value;
      REG_PRESS_CALIB_B: press_cal_b = value;
      default:           press_cal_c = value[31:0];
    endcase
    @(negedge clk);
  endtask

  task automatic load_calib(logic [47:0] tc, logic [47:0] pa, logic [47:0] pb,
                            logic [47:0] pc);
    write_reg(REG_TEMP_CALIB, tc);
    write_reg(REG_PRESS_CALIB_A, pa);
    write_reg(REG_PRESS_CALIB_B, pb);
    write_reg(REG_PRESS_CALIB_C, pc);
    cfg_write <= 1'b0;
  endtask

  // Offer one item, after a random idle gap at the start of a burst, and hold it until it is taken
  int burst_left = 0;
  task automatic send_item(in_item_t item, bit known, out_item_t result);
    int seen, gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    in_data     <= item;
    pend_known  <= known;
    pend_result <= result;
    seen = accepted_items;
    do @(negedge clk); while (accepted_items == seen);
  endtask

  // Let the pipeline empty before touching the registers
  task automatic drain();
    in_valid <= 1'b0;
    pend_known <= 1'b0;
    @(negedge clk);
    while (expected_q.size() != 0) @(negedge clk);
    repeat (PIPE_CYCLES + 4) @(negedge clk);
  endtask

  // Raw temperature mostly near the calibration point, sometimes anywhere
  function automatic in_item_t random_reading();
    in_item_t x;
    int off;
    x.raw_pressure = 24'($urandom_range(24'hFFFFFF));
    if ($urandom_range(9) < 7) begin
      off = int'($urandom_range(1 << 20)) - (1 << 19);
      x.raw_temperature = 24'(int'({temp_cal[15:0], 8'h00}) + off);
    end else begin
      x.raw_temperature = 24'($urandom_range(24'hFFFFFF));
    end
    return x;
  endfunction

  typedef struct {
    logic [23:0]        press;
    logic [23:0]        temp;
    bit                 known;
    logic signed [31:0] exp_press;
  } dir_row_t;

  dir_row_t  dir_rows[8];
  in_item_t  item;
  out_item_t res;

  initial begin
    temp_cal = '0; press_cal_a = '0; press_cal_b = '0; press_cal_c = '0;
    // With cleared calibration, temperature is zero and pressure is minus the raw reading
    dir_rows = '{
      '{24'h000000, 24'h000000, 1'b1, 32'sd0},
      '{24'hFFFFFF, 24'hFFFFFF, 1'b1, -32'sd16777215},
      '{24'h000001, 24'h800000, 1'b1, -32'sd1},
      '{24'h800000, 24'h7FFFFF, 1'b1, -32'sd8388608},
      '{24'h7FFFFF, 24'h000001, 1'b1, -32'sd8388607},
      '{24'hAAAAAA, 24'h555555, 1'b1, -32'sd11184810},
      '{24'h555555, 24'hAAAAAA, 1'b1, -32'sd5592405},
      '{24'h6B0000, 24'h820000, 1'b0, 32'sd0}
    };
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset calibration, then saturating temperature both ways
    foreach (dir_rows[i]) begin
      item.raw_pressure = dir_rows[i].press;
      item.raw_temperature = dir_rows[i].temp;
      res.pressure_out = dir_rows[i].exp_press;
      res.temperature_lin = '0;
      send_item(item, dir_rows[i].known, res);
    end
    drain();
    load_calib(48'h00FF_FFFF_0000, 48'h7F7F_7FFF_7FFF, 48'h7F7F_FFFF_FFFF,
               48'h0000_7F7F_7FFF);
    foreach (dir_rows[i]) begin
      item.raw_pressure = dir_rows[i].press;
      item.raw_temperature = dir_rows[i].temp;
      send_item(item, 0, res);
    end
    drain();
    load_calib(48'h0080_FFFF_FFFF, 48'h8080_8000_8000, 48'h8080_0000_0000,
               48'h0000_8080_8000);
    foreach (dir_rows[i]) begin
      item.raw_pressure = dir_rows[i].press;
      item.raw_temperature = dir_rows[i].temp;
      send_item(item, 0, res);
    end
    drain();

    // Random phases, each under its own calibration
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_calib({8'h00, 8'hF9, 16'd19000 + 16'($urandom_range(2000)), 16'd27000},
                      {8'hFD, 8'h05, 16'hFF00 + 16'($urandom_range(200)), 16'd600},
                      {8'h14, 8'hFE, 16'd24000, 16'd6000},
                      {16'h0000, 8'hF4, 8'h0A, 16'd3000});
        1: load_calib('1, '1, '1, '1);
        2: load_calib('0, '0, '0, '0);
        3: load_calib({8'h00, 8'h7F, 16'hFFFF, 16'h0000}, 48'({$urandom, $urandom}),
                      48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
        4: load_calib({8'h00, 8'h80, 16'hFFFF, 16'hFFFF}, 48'({$urandom, $urandom}),
                      48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
        default: load_calib(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                            48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
      endcase
      for (int n = 0; n < N_RANDOM / 6; n++) begin
        // Hold the output off once while items keep coming
        if (ph == 2 && n == 20) hold_off_req = 1'b1;
        send_item(random_reading(), 0, res);
      end
      drain();
    end

    $display("Checked %0d results over %0d items, %0d with saturated temperature,",
             checked_items, accepted_items, sat_items);
    $display("across reset, extreme and random calibrations with random stalls.");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
